// ----- rtl/tlv_stream_deframer_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the TLV stream deframer
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TLV_STREAM_DEFRAMER_TOP_MACROS_SVH
`define TLV_STREAM_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication
`define TLV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tlvdfr_pkg.sv -----
// ---------------------------------------------------------------------------
// TLV deframer package
// Types and constants shared by the deframer core and top level.
// ---------------------------------------------------------------------------
package tlvdfr_pkg;

  // Saturation ceiling of the completed-object counter
  localparam logic [4:0] COUNT_CEIL = 5'd31;

  // Zero padding of the result tdata to whole bytes
  localparam int unsigned RES_PAD_W = 4;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_TYPE   = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_LEN_HI = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_e;

  // Role of a byte within its object
  typedef enum logic [1:0] {
    ROLE_TYPE   = 2'd0,
    ROLE_LEN_LO = 2'd1,
    ROLE_LEN_HI = 2'd2,
    ROLE_DATA   = 2'd3
  } role_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  // One result per input byte
  typedef struct packed {
    role_e        role;
    logic [7:0]   data_byte;
    logic [3:0]   object_index;
    logic [7:0]   object_type;
    logic [15:0]  object_size;
    logic         object_end;
    logic         message_end;
    logic [4:0]   object_count;
    status_e      status;
  } res_t;

endpackage

// ----- rtl/tlvdfr_core.sv -----
// ---------------------------------------------------------------------------
// TLV deframer core
// Holds the parse state; one byte's result per cycle while step_i is high.
// ---------------------------------------------------------------------------
module tlvdfr_core import tlvdfr_pkg::*; #(
  parameter int unsigned MAX_OBJECTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,       // byte accepted this cycle
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output res_t       res_o
);

  localparam logic [7:0] MaxObj = 8'(MAX_OBJECTS);

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] size_q, size_d;
  logic [15:0] left_q, left_d;
  logic [4:0]  done_q, done_d;
  logic        disc_q, disc_d;

  logic [15:0] size_hi;
  logic [15:0] left_dec;
  logic        full;
  logic        finish;

  assign size_hi  = {byte_i, size_q[7:0]};
  assign left_dec = left_q - 16'd1;
  assign full     = ({3'b000, done_q} >= MaxObj) || (done_q >= COUNT_CEIL);

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    size_d  = size_q;
    left_d  = left_q;
    disc_d  = disc_q;
    finish  = 1'b0;

    res_o              = '0;
    res_o.role         = ROLE_TYPE;
    res_o.status       = ST_OK;
    res_o.data_byte    = byte_i;
    res_o.message_end  = last_i;
    res_o.object_index = done_q[3:0];

    if (disc_q) begin
      res_o.status = ST_TOO_MANY;
    end else begin
      unique case (phase_q)
        PH_TYPE: begin
          if (full) begin
            disc_d       = 1'b1;
            res_o.status = ST_TOO_MANY;
          end else begin
            type_d            = byte_i;
            size_d            = '0;
            res_o.object_type = byte_i;
            phase_d           = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          res_o.role        = ROLE_LEN_LO;
          size_d            = {8'h00, byte_i};
          res_o.object_type = type_q;
          phase_d           = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          res_o.role        = ROLE_LEN_HI;
          size_d            = size_hi;
          res_o.object_type = type_q;
          res_o.object_size = size_hi;
          if (size_hi == 16'd0) begin
            res_o.object_end = 1'b1;
            finish           = 1'b1;
          end else begin
            left_d  = size_hi;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          res_o.role        = ROLE_DATA;
          res_o.object_type = type_q;
          res_o.object_size = size_q;
          left_d            = left_dec;
          if (left_dec == 16'd0) begin
            res_o.object_end = 1'b1;
            finish           = 1'b1;
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
    end

    // Object completion: saturating count, back to type byte
    done_d = done_q;
    if (finish) begin
      phase_d = PH_TYPE;
      if (done_q < COUNT_CEIL) begin
        done_d = done_q + 5'd1;
      end
    end

    // Message ends mid-object
    if (last_i && (res_o.status == ST_OK) && (phase_d != PH_TYPE)) begin
      res_o.status = ST_TRUNC;
    end
    res_o.object_count = done_d;
  end

  // State registers; cleared after the last byte of a message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      size_q  <= '0;
      left_q  <= '0;
      done_q  <= '0;
      disc_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_TYPE;
        type_q  <= '0;
        size_q  <= '0;
        left_q  <= '0;
        done_q  <= '0;
        disc_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        type_q  <= type_d;
        size_q  <= size_d;
        left_q  <= left_d;
        done_q  <= done_d;
        disc_q  <= disc_d;
      end
    end
  end

endmodule

// ----- rtl/tlv_stream_deframer_top.sv -----
// A transfer's result is registered and shows on the master side next cycle.
// Throughput: one byte per cycle; the result register frees as it is taken,
// so the block stalls only while a result waits on m_axis_tready_i.
// Reset: rst_ni clears the parse state and the result valid at once;
// state also clears after each byte marked with tlast.
// ---------------------------------------------------------------------------
// TLV stream deframer top level
// Splits a byte stream into type-length-value objects, one result per byte.
// ---------------------------------------------------------------------------
`include "tlv_stream_deframer_top_macros.svh"

module tlv_stream_deframer_top import tlvdfr_pkg::*; #(
  parameter int unsigned MAX_OBJECTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tlast_i,   // last_byte
  // Results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [11:8] object_index, [19:12] object_type,
  // [35:20] object_size, [36] object_end, [41:37] object_count,
  // [43:42] status, [47:44] zero
  output logic [47:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] role
  output logic        m_axis_tlast_o    // message_end
);

  logic in_xfer;
  logic out_valid_q;
  res_t res;
  res_t res_q;

  // Accept while the result register is empty or being emptied
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  tlvdfr_core #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .res_o  (res)
  );

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.role;
  assign m_axis_tlast_o  = res_q.message_end;
  assign m_axis_tdata_o  = {{RES_PAD_W{1'b0}}, res_q.status, res_q.object_count,
                            res_q.object_end, res_q.object_size, res_q.object_type,
                            res_q.object_index, res_q.data_byte};

  // Checks
  `TLV_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_q, "accepted byte lost its result")
  `TLV_ASSERT_NOW(a_end_role, out_valid_q && res_q.object_end,
    (res_q.role == ROLE_LEN_HI) || (res_q.role == ROLE_DATA), "object end on a header byte")
  `TLV_ASSERT_NOW(a_discard_shape, out_valid_q && (res_q.status == ST_TOO_MANY),
    (res_q.role == ROLE_TYPE) && !res_q.object_end && (res_q.object_type == 8'h00),
    "discarded byte carries object fields")
  `TLV_ASSERT_NOW(a_trunc_last, out_valid_q && (res_q.status == ST_TRUNC),
    res_q.message_end && !res_q.object_end, "truncation flagged away from message end")

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// TLV stream deframer testbench
// Sends messages of type-length-value objects one byte per transfer, with
// random gaps on both stream sides, and checks each result against a
// parse of the same byte stream. Covers zero-length objects, large declared
// sizes, truncated messages, the object limit, well-formed random traffic.
// ---------------------------------------------------------------------------
module tb;
  import tlvdfr_pkg::*;

  localparam int unsigned MAX_OBJECTS = 16;
  localparam int unsigned ITEMS       = 850;
  localparam int unsigned IDLE_PCT    = 13;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] byte_value
  logic        s_axis_tlast_i = 1'b0; // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] data_byte, [11:8] object_index, [19:12] object_type,
  // [35:20] object_size, [36] object_end, [41:37] object_count,
  // [43:42] status, [47:44] zero
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;        // [1:0] role
  logic        m_axis_tlast_o;        // message_end

  tlv_stream_deframer_top #(
    .MAX_OBJECTS(MAX_OBJECTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state mirrored by the testbench
  phase_e      parse_phase = PH_TYPE;
  logic [7:0]  cur_type = '0;
  logic [15:0] decl_size = '0;
  logic [15:0] bytes_left = '0;
  logic [4:0]  objs_done = '0;
  logic        discarding = 1'b0;

  res_t        byte_results_q[$];
  logic [7:0]  msg_bytes[$];
  bit          idle_en = 1'b1;

  int unsigned n_errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_msgs = 0;
  int unsigned n_objects = 0;
  int unsigned n_overruns = 0;
  int unsigned n_trunc = 0;
  int unsigned cycles = 0;

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               byte_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  // Expected result of one accepted byte; advances the mirrored state
  function automatic res_t parse_byte(input logic [7:0] b, input logic last);
    res_t    r;
    status_e st;
    r = '0;
    r.role = ROLE_TYPE;
    r.data_byte = b;
    r.object_index = objs_done[3:0];
    st = ST_OK;
    if (discarding) begin
      st = ST_TOO_MANY;
    end else begin
      case (parse_phase)
        PH_TYPE: begin
          if (32'(objs_done) >= MAX_OBJECTS || objs_done >= COUNT_CEIL) begin
            discarding = 1'b1;
            st = ST_TOO_MANY;
            n_overruns++;
          end else begin
            cur_type = b;
            decl_size = '0;
            r.object_type = b;
            parse_phase = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          r.role = ROLE_LEN_LO;
          decl_size = {8'h00, b};
          r.object_type = cur_type;
          parse_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          r.role = ROLE_LEN_HI;
          decl_size = {b, decl_size[7:0]};
          r.object_type = cur_type;
          r.object_size = decl_size;
          if (decl_size == 16'd0) begin
            r.object_end = 1'b1;
          end else begin
            bytes_left = decl_size;
            parse_phase = PH_DATA;
          end
        end
        default: begin
          r.role = ROLE_DATA;
          r.object_type = cur_type;
          r.object_size = decl_size;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) r.object_end = 1'b1;
        end
      endcase
      // object complete: count saturates, back to expecting a type byte
      if (r.object_end) begin
        if (objs_done < COUNT_CEIL) objs_done = objs_done + 5'd1;
        parse_phase = PH_TYPE;
        n_objects++;
      end
    end
    if (last && st == ST_OK && parse_phase != PH_TYPE) begin
      st = ST_TRUNC;
      n_trunc++;
    end
    r.message_end = last;
    r.object_count = objs_done;
    r.status = st;
    n_bytes++;
    // next message starts afresh
    if (last) begin
      n_msgs++;
      parse_phase = PH_TYPE;
      cur_type = '0;
      decl_size = '0;
      bytes_left = '0;
      objs_done = '0;
      discarding = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("cycle %0d: %s got 0x%0h, expected 0x%0h", cycles, what, got, want);
  endtask

  // Compare the result on the master side with the oldest expectation
  task automatic check_result();
    res_t want;
    if (byte_results_q.size() == 0) begin
      report_mismatch("result with nothing expected, data", m_axis_tdata_o[15:0], '0);
      return;
    end
    want = byte_results_q.pop_front();
    if (m_axis_tuser_o != want.role)
      report_mismatch("role", 16'(m_axis_tuser_o), 16'(want.role));
    if (m_axis_tdata_o[7:0] != want.data_byte)
      report_mismatch("data_byte", 16'(m_axis_tdata_o[7:0]), 16'(want.data_byte));
    if (m_axis_tdata_o[11:8] != want.object_index)
      report_mismatch("object_index", 16'(m_axis_tdata_o[11:8]),
                      16'(want.object_index));
    if (m_axis_tdata_o[19:12] != want.object_type)
      report_mismatch("object_type", 16'(m_axis_tdata_o[19:12]),
                      16'(want.object_type));
    if (m_axis_tdata_o[35:20] != want.object_size)
      report_mismatch("object_size", m_axis_tdata_o[35:20], want.object_size);
    if (m_axis_tdata_o[36] != want.object_end)
      report_mismatch("object_end", 16'(m_axis_tdata_o[36]), 16'(want.object_end));
    if (m_axis_tlast_o != want.message_end)
      report_mismatch("message_end", 16'(m_axis_tlast_o), 16'(want.message_end));
    if (m_axis_tdata_o[41:37] != want.object_count)
      report_mismatch("object_count", 16'(m_axis_tdata_o[41:37]),
                      16'(want.object_count));
    if (m_axis_tdata_o[43:42] != want.status)
      report_mismatch("status", 16'(m_axis_tdata_o[43:42]), 16'(want.status));
    if (m_axis_tdata_o[47:44] != 4'd0)
      report_mismatch("tdata padding", 16'(m_axis_tdata_o[47:44]), 16'd0);
  endtask

  // Outputs are stable from the falling edge; a transfer seen here
  // completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result();
  end

  // One byte transfer; called and returns just after a rising edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    byte_results_q.push_back(parse_byte(b, last));
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // Hold off the sender until every result has come back
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (byte_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_object(input logic [7:0] t, input logic [15:0] sz);
    msg_bytes.push_back(t);
    msg_bytes.push_back(sz[7:0]);
    msg_bytes.push_back(sz[15:8]);
    repeat (sz) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  // An object cut short by the end of the message
  task automatic add_broken_tail();
    logic [7:0]  part[$];
    logic [15:0] sz;
    int          ndata;
    int          keep;
    sz = ($urandom_range(1) != 0) ? 16'($urandom_range(65535))
                                  : 16'($urandom_range(0, 8));
    part.push_back(8'($urandom_range(255)));
    part.push_back(sz[7:0]);
    part.push_back(sz[15:8]);
    if (sz == 16'd0) begin
      keep = $urandom_range(1, 2);
    end else begin
      ndata = $urandom_range(0, (sz > 16'd6) ? 6 : int'(sz) - 1);
      repeat (ndata) part.push_back(8'($urandom_range(255)));
      keep = $urandom_range(1, part.size());
    end
    for (int i = 0; i < keep; i++) msg_bytes.push_back(part[i]);
  endtask

  // Mostly well-formed messages, some cut short, some plain noise
  task automatic build_random_message();
    int          sel;
    int          nobj;
    logic [15:0] sz;
    msg_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 70) begin
      nobj = ($urandom_range(99) < 15) ? $urandom_range(14, 20) : $urandom_range(1, 5);
      repeat (nobj) begin
        if (nobj > 5) sz = 16'($urandom_range(0, 3));
        else sz = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
        add_object(8'($urandom_range(255)), sz);
      end
      if ($urandom_range(3) == 0) add_broken_tail();
    end else if (sel < 85) begin
      add_broken_tail();
    end else begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // Field extremes, every byte role, cuts in each phase
  task automatic test_directed();
    msg_bytes = '{8'hFF};                               // lone type byte
    send_message();
    msg_bytes = '{8'h00, 8'h00, 8'h00};                 // zero length object
    send_message();
    msg_bytes = '{8'hA5, 8'h01, 8'h00, 8'hFF};          // one data byte
    send_message();
    msg_bytes = '{8'h3C, 8'h02};                        // cut after length low
    send_message();
    msg_bytes = '{8'h7E, 8'hFF, 8'hFF};                 // maximum size, cut
    send_message();
    msg_bytes = '{8'h11, 8'h03, 8'h00, 8'hAA, 8'h55};   // cut inside data
    send_message();
    msg_bytes = '{8'h01, 8'h00, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h03};
    send_message();
  endtask

  // Object limit reached, rest of message discarded, next message clean
  task automatic test_object_limit();
    msg_bytes.delete();
    repeat (MAX_OBJECTS) add_object(8'($urandom_range(255)), 16'd0);
    repeat (4) msg_bytes.push_back(8'($urandom_range(255)));
    send_message();
    msg_bytes.delete();
    repeat (MAX_OBJECTS)
      add_object(8'($urandom_range(255)), 16'($urandom_range(0, 2)));
    msg_bytes.push_back(8'h5A);                         // overrun on last byte
    send_message();
    msg_bytes.delete();
    add_object(8'h42, 16'd1);
    send_message();
  endtask

  // Sender pauses until the block has gone quiet, then resumes
  task automatic test_drain_pause();
    repeat (3) begin
      build_random_message();
      send_message();
      wait_drained();
    end
  endtask

  // Long stretch with no gaps on either side
  task automatic test_back_to_back();
    int unsigned start;
    start = n_bytes;
    idle_en = 1'b0;
    while (n_bytes < start + 150) begin
      build_random_message();
      send_message();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    while (n_bytes < ITEMS) begin
      build_random_message();
      send_message();
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_object_limit();
    test_drain_pause();
    test_back_to_back();
    test_random();
    wait_drained();
    repeat (5) @(posedge clk_i);
    $display("Parsed %0d bytes in %0d messages: %0d objects completed,", n_bytes,
             n_msgs, n_objects);
    $display("%0d object limit overruns, %0d truncated endings, %0d mismatches",
             n_overruns, n_trunc, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
